>>> rtl/dlefr_pkg.sv
// ============================================================================
// DLE framed link receiver package
// Shared payload types, codes, link characters and the CRC-16 byte update.
// ============================================================================
package dlefr_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int MIN_BODY_BYTES   = 6;
    localparam int TICKS_W          = 20;
    localparam int CFG_DATA_W       = 20;
    localparam int CFG_INDEX_W      = 2;
    localparam int INDEX_W          = 9;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd5001;

    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_NAK = 8'h15;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        OP_BYTE   = 3'd0,
        OP_TICK   = 3'd1,
        OP_ENQ    = 3'd2,
        OP_ACCEPT = 3'd3,
        OP_REJECT = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BODY = 3'd1,
        PH_CHK1 = 3'd2,
        PH_CHK2 = 3'd3,
        PH_PEND = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NAK  = 2'd2
    } reply_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_RUNT    = 3'd1,
        EV_BAD_CHK = 3'd2,
        EV_DUP     = 3'd3,
        EV_TIMEOUT = 3'd4,
        EV_OVF     = 3'd5,
        EV_LATE    = 3'd6
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_USE_CRC   = 2'd0,
        CFG_DUP_CHECK = 2'd1,
        CFG_TIMEOUT   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         reply;
        logic [1:0]         embedded_reply;
        logic               body_valid;
        logic [7:0]         body_byte;
        logic [INDEX_W-1:0] body_index;
        logic               message_done;
        logic [2:0]         event_res;
        logic               receiving;
    } out_item_t;

    typedef struct packed {
        logic               use_crc;
        logic               dup_check;
        logic [TICKS_W-1:0] timeout_ticks;
    } cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/dlefr_core.sv
// ============================================================================
// DLE framed link receiver core
// Message state registers and the single-pass update for one item.
// ============================================================================
module dlefr_core #(
    parameter int BUFFER_BYTES = dlefr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  dlefr_pkg::in_item_t  item,
    input  dlefr_pkg::cfg_t      cfg,
    output dlefr_pkg::out_item_t result
);

    localparam int LEN_W = $clog2(BUFFER_BYTES + 1);
    localparam int IDX_W = dlefr_pkg::INDEX_W;

    dlefr_pkg::phase_t           phase_reg, phase_next;
    logic [dlefr_pkg::TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic                        esc_reg, esc_next;
    logic                        ovf_reg, ovf_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [15:0]                 crc_reg, crc_next;
    logic [7:0]                  bcc_reg, bcc_next;
    logic [15:0]                 rchk_reg, rchk_next;
    logic [31:0]                 cur_key_reg, cur_key_next;
    logic [31:0]                 prev_key_reg, prev_key_next;
    logic                        last_ack_reg, last_ack_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= dlefr_pkg::PH_IDLE;
            elapsed_reg  <= '0;
            esc_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            len_reg      <= '0;
            crc_reg      <= '0;
            bcc_reg      <= '0;
            rchk_reg     <= '0;
            cur_key_reg  <= '0;
            prev_key_reg <= '0;
            last_ack_reg <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            esc_reg      <= esc_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            crc_reg      <= crc_next;
            bcc_reg      <= bcc_next;
            rchk_reg     <= rchk_next;
            cur_key_reg  <= cur_key_next;
            prev_key_reg <= prev_key_next;
            last_ack_reg <= last_ack_next;
        end
    end

    always_comb begin
        logic [7:0]                  b;
        logic                        store;
        logic                        do_finish;
        logic                        good;
        logic [dlefr_pkg::TICKS_W:0] tick_sum;

        b         = item.data_byte;
        store     = 1'b0;
        do_finish = 1'b0;
        good      = 1'b0;
        tick_sum  = {1'b0, elapsed_reg} + 1'b1;

        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        esc_next      = esc_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        bcc_next      = bcc_reg;
        rchk_next     = rchk_reg;
        cur_key_next  = cur_key_reg;
        prev_key_next = prev_key_reg;
        last_ack_next = last_ack_reg;
        result        = '0;

        unique case (item.operation)
            dlefr_pkg::OP_BYTE: begin
                if (phase_reg == dlefr_pkg::PH_IDLE) begin
                    len_next     = '0;
                    elapsed_next = '0;
                    esc_next     = 1'b0;
                    ovf_next     = 1'b0;
                    crc_next     = '0;
                    bcc_next     = '0;
                    cur_key_next = '0;
                    phase_next   = dlefr_pkg::PH_BODY;
                end
                unique case (phase_next)
                    dlefr_pkg::PH_BODY: begin
                        if (esc_next) begin
                            if (b == dlefr_pkg::CH_ETX) begin
                                if (cfg.use_crc) begin
                                    crc_next = dlefr_pkg::crc_byte(crc_next, dlefr_pkg::CH_ETX);
                                end
                                phase_next = dlefr_pkg::PH_CHK1;
                            end else if (b == dlefr_pkg::CH_ACK || b == dlefr_pkg::CH_NAK) begin
                                esc_next = 1'b0;
                                result.embedded_reply = (b == dlefr_pkg::CH_ACK)
                                    ? dlefr_pkg::RPL_ACK : dlefr_pkg::RPL_NAK;
                            end else if (b != dlefr_pkg::CH_DLE) begin
                                last_ack_next = 1'b0;
                            end else begin
                                store = 1'b1;
                            end
                        end else if (b == dlefr_pkg::CH_DLE) begin
                            esc_next = 1'b1;
                        end else begin
                            store = 1'b1;
                        end
                        if (store) begin
                            esc_next = 1'b0;
                            if (!ovf_next) begin
                                if (len_next < LEN_W'(BUFFER_BYTES)) begin
                                    result.body_valid = 1'b1;
                                    result.body_byte  = b;
                                    result.body_index = IDX_W'(len_next);
                                    if (len_next == LEN_W'(1)) cur_key_next[7:0]   = b;
                                    if (len_next == LEN_W'(2)) cur_key_next[15:8]  = b;
                                    if (len_next == LEN_W'(4)) cur_key_next[23:16] = b;
                                    if (len_next == LEN_W'(5)) cur_key_next[31:24] = b;
                                    len_next = len_next + 1'b1;
                                end else begin
                                    ovf_next         = 1'b1;
                                    result.event_res = dlefr_pkg::EV_OVF;
                                end
                            end
                            if (cfg.use_crc) begin
                                crc_next = dlefr_pkg::crc_byte(crc_next, b);
                            end else begin
                                bcc_next = bcc_next + b;
                            end
                        end
                    end
                    dlefr_pkg::PH_CHK1: begin
                        rchk_next = {8'h00, b};
                        if (cfg.use_crc) begin
                            phase_next = dlefr_pkg::PH_CHK2;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                    dlefr_pkg::PH_CHK2: begin
                        rchk_next = {b, rchk_reg[7:0]};
                        do_finish = 1'b1;
                    end
                    default: ;
                endcase
            end
            dlefr_pkg::OP_TICK: begin
                if (phase_reg == dlefr_pkg::PH_BODY || phase_reg == dlefr_pkg::PH_CHK1 ||
                    phase_reg == dlefr_pkg::PH_CHK2) begin
                    if (tick_sum > {1'b0, cfg.timeout_ticks}) begin
                        phase_next       = dlefr_pkg::PH_IDLE;
                        last_ack_next    = 1'b0;
                        result.event_res = dlefr_pkg::EV_TIMEOUT;
                    end else begin
                        elapsed_next = tick_sum[dlefr_pkg::TICKS_W-1:0];
                    end
                end
            end
            dlefr_pkg::OP_ENQ: begin
                phase_next = dlefr_pkg::PH_IDLE;
                if (phase_reg == dlefr_pkg::PH_PEND) begin
                    result.event_res = dlefr_pkg::EV_LATE;
                    result.reply     = dlefr_pkg::RPL_ACK;
                    last_ack_next    = 1'b1;
                end else begin
                    result.reply = last_ack_reg ? dlefr_pkg::RPL_ACK : dlefr_pkg::RPL_NAK;
                end
            end
            dlefr_pkg::OP_ACCEPT, dlefr_pkg::OP_REJECT: begin
                if (phase_reg == dlefr_pkg::PH_PEND) begin
                    phase_next    = dlefr_pkg::PH_IDLE;
                    last_ack_next = (item.operation == dlefr_pkg::OP_ACCEPT);
                    result.reply  = last_ack_next ? dlefr_pkg::RPL_ACK : dlefr_pkg::RPL_NAK;
                end
            end
            default: ;
        endcase

        if (do_finish) begin
            if (cfg.use_crc) begin
                good = (crc_next == rchk_next);
            end else begin
                good = ((8'h00 - bcc_next) == rchk_next[7:0]);
            end
            phase_next = dlefr_pkg::PH_IDLE;
            if (len_next < LEN_W'(dlefr_pkg::MIN_BODY_BYTES)) begin
                result.event_res = dlefr_pkg::EV_RUNT;
                result.reply     = dlefr_pkg::RPL_NAK;
                last_ack_next    = 1'b0;
            end else if (!good) begin
                result.event_res = dlefr_pkg::EV_BAD_CHK;
                result.reply     = dlefr_pkg::RPL_NAK;
                last_ack_next    = 1'b0;
            end else if (cfg.dup_check && cur_key_next == prev_key_reg) begin
                prev_key_next    = cur_key_next;
                result.event_res = dlefr_pkg::EV_DUP;
                result.reply     = dlefr_pkg::RPL_ACK;
                last_ack_next    = 1'b1;
            end else begin
                if (cfg.dup_check) begin
                    prev_key_next = cur_key_next;
                end
                phase_next          = dlefr_pkg::PH_PEND;
                result.message_done = 1'b1;
            end
        end

        result.receiving = (phase_next == dlefr_pkg::PH_BODY ||
                            phase_next == dlefr_pkg::PH_CHK1 ||
                            phase_next == dlefr_pkg::PH_CHK2);
    end

endmodule

>>> rtl/dle_framed_link_receiver.sv
// ============================================================================
// DLE framed link receiver
// Unstuffs a DLE framed message body, checks BCC or CRC-16, length and
// duplicates, and produces link replies and streamed body bytes.
// ============================================================================
// Path: input transfer into the input register, then one pass of the message
//   update into the result register, which drives result valid.
// Throughput: one item per cycle while the result is free or taken by m_ready;
//   the result register is set by the byte-wide CRC update and final check compare.
// Reset: synchronous, active low; state, config and valid flags take reset values, item registers do not.
module dle_framed_link_receiver #(
    parameter int BUFFER_BYTES = dlefr_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dlefr_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dlefr_pkg::out_item_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlefr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dlefr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                 in_valid_reg;
    dlefr_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg;
    dlefr_pkg::out_item_t out_item_reg;
    dlefr_pkg::cfg_t      cfg_reg;
    dlefr_pkg::out_item_t result;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.use_crc       <= 1'b0;
            cfg_reg.dup_check     <= 1'b1;
            cfg_reg.timeout_ticks <= dlefr_pkg::TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                dlefr_pkg::CFG_USE_CRC:   cfg_reg.use_crc       <= cfg_data[0];
                dlefr_pkg::CFG_DUP_CHECK: cfg_reg.dup_check     <= cfg_data[0];
                dlefr_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    dlefr_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

>>> rtl/dlefr_checker.sv
// ============================================================================
// DLE framed link receiver checker
// Port-level properties of the result stream, bound to the top level.
// ============================================================================
module dlefr_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input dlefr_pkg::in_item_t  s_data,
    input logic                 m_valid,
    input logic                 m_ready,
    input dlefr_pkg::out_item_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_body_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.body_valid |->
            m_data.reply == dlefr_pkg::RPL_NONE && !m_data.message_done &&
            m_data.event_res == dlefr_pkg::EV_NONE && m_data.receiving)
        else $error("body byte with another event");

    a_done_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.message_done |->
            m_data.event_res == dlefr_pkg::EV_NONE && !m_data.receiving &&
            m_data.reply == dlefr_pkg::RPL_NONE)
        else $error("message handed on with error or reply");

    a_reply_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reply != dlefr_pkg::RPL_NONE |-> !m_data.receiving)
        else $error("reply while still receiving");

    a_first_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.operation == dlefr_pkg::OP_BYTE |=>
            ##1 !(m_valid && m_data.message_done && m_data.body_valid))
        else $error("done and body byte together");

endmodule

bind dle_framed_link_receiver dlefr_checker u_dlefr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
